/* hw/rtl/bpr_pkg.sv */
`default_nettype none

package bpr_pkg;

  localparam int NUM_ITEMS   = 1024;
  localparam int FACTORS     = 16;
  localparam int SIG_ENTRIES = 256;

  localparam int ITEM_W = 10;
  localparam int FIDX_W = 4;
  localparam int WORD_W = 32;
  localparam int CFG_W  = 16;

  localparam int AW     = $clog2(NUM_ITEMS * FACTORS);
  localparam int FW     = (FACTORS > 1) ? $clog2(FACTORS) : 1;
  localparam int SIG_IW = (SIG_ENTRIES > 1) ? $clog2(SIG_ENTRIES) : 1;
  localparam int ACC_W  = 48 + FW + 1;

  localparam longint HALF_RANGE = 524288;

  localparam logic [CFG_W-1:0] STEP_SIZE_RESET  = 16'd328;
  localparam logic [CFG_W-1:0] REG_LAMBDA_RESET = 16'd655;

  localparam logic REG_STEP_SIZE = 1'b0;
  localparam logic REG_LAMBDA    = 1'b1;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_PREDICT = 2'd2;
  localparam logic [1:0] CMD_UPDATE  = 2'd3;

  localparam logic [1:0] ROW_CTX = 2'd0;
  localparam logic [1:0] ROW_POS = 2'd1;
  localparam logic [1:0] ROW_NEG = 2'd2;

  localparam logic [1:0] SG_CTX = 2'd0;
  localparam logic [1:0] SG_POS = 2'd1;
  localparam logic [1:0] SG_NEG = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [ITEM_W-1:0]       context_item;
    logic [ITEM_W-1:0]       target_item;
    logic [ITEM_W-1:0]       negative_item;
    logic                    table_select;
    logic [FIDX_W-1:0]       factor_index;
    logic signed [WORD_W-1:0] weight_value;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] score;
    logic signed [WORD_W-1:0] read_weight;
    logic                     saturated;
  } out_word_t;

  typedef struct packed {
    logic          cap_in;
    logic          use_fidx;
    logic [FW-1:0] fcnt;
    logic          ctx_re;
    logic          ctx_we;
    logic          tgt_re;
    logic          tgt_we;
    logic [1:0]    tgt_row;
    logic          wsrc_in;
    logic          ld_g;
    logic          ld_p;
    logic          ld_n;
    logic          ld_b;
    logic          mul;
    logic          acc_add;
    logic          ld_score;
    logic          ld_d;
    logic          ld_rd;
    logic [1:0]    sg_op;
    logic          sg_commit;
    logic          ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       tsel;
  } dp_stat_t;

  typedef logic [15:0] sig_table_t [SIG_ENTRIES];

  // Restoring long division, used only while the sigmoid table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_table_t sig_build();
    sig_table_t  tab;
    longint      c;
    logic [63:0] a;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] den;
    logic [63:0] dv;
    int          i;
    int          k;
    for (k = 0; k < SIG_ENTRIES; k++) begin
      c = -HALF_RANGE + ((2 * longint'(k) + 1) * HALF_RANGE) / SIG_ENTRIES;
      a = (c < 0) ? 64'(-c) : 64'(c);
      sum = 64'd0;
      term = 64'd1 << 32;
      for (i = 1; term != 64'd0 && i < 64; i++) begin
        sum = sum + term;
        term = div_u64((term * a) >> 16, 64'(i));
      end
      den = (64'd1 << 32) + sum;
      dv = div_u64((64'd1 << 48) + (den >> 1), den);
      tab[k] = (c >= 0) ? dv[15:0] : 16'(64'd65536 - dv);
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = sig_build();

  // Saturates to 32 bits; bit 32 of the result flags a clipped value.
  function automatic logic [32:0] sat32(logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bpr_ram.sv */
`default_nettype none

module bpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/bpr_ctrl.sv */
`default_nettype none

module bpr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire bpr_pkg::dp_stat_t  stat_i,
  output bpr_pkg::dp_cmd_t        cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_WR     = 5'd2;
  localparam logic [4:0] S_RD1    = 5'd3;
  localparam logic [4:0] S_RD2    = 5'd4;
  localparam logic [4:0] S_D_RD1  = 5'd5;
  localparam logic [4:0] S_D_RD2  = 5'd6;
  localparam logic [4:0] S_D_LDN  = 5'd7;
  localparam logic [4:0] S_D_B    = 5'd8;
  localparam logic [4:0] S_D_MUL  = 5'd9;
  localparam logic [4:0] S_D_ACC  = 5'd10;
  localparam logic [4:0] S_D_SAT  = 5'd11;
  localparam logic [4:0] S_LOOK   = 5'd12;
  localparam logic [4:0] S_U_RD1  = 5'd13;
  localparam logic [4:0] S_U_RD2  = 5'd14;
  localparam logic [4:0] S_U_LDN  = 5'd15;
  localparam logic [4:0] S_U_DIFF = 5'd16;
  localparam logic [4:0] S_SG_A   = 5'd17;
  localparam logic [4:0] S_SG_B   = 5'd18;
  localparam logic [4:0] S_SG_C   = 5'd19;
  localparam logic [4:0] S_SG_W   = 5'd20;
  localparam logic [4:0] S_FIN    = 5'd21;

  localparam logic [bpr_pkg::FW-1:0] F_LAST = bpr_pkg::FW'(bpr_pkg::FACTORS - 1);

  logic [4:0]             state_q, state_d;
  logic [bpr_pkg::FW-1:0] f_q, f_d;
  logic [1:0]             op_q, op_d;
  logic                   out_valid_q, out_valid_d;
  logic                   is_update;

  assign is_update = (stat_i.cmd == bpr_pkg::CMD_UPDATE);

  always_comb begin
    state_d     = state_q;
    f_d         = f_q;
    op_d        = op_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.fcnt  = f_q;
    cmd_o.sg_op = op_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.cap_in = in_valid_i;
        f_d          = '0;
        if (in_valid_i) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.cmd)
          bpr_pkg::CMD_WRITE: state_d = S_WR;
          bpr_pkg::CMD_READ:  state_d = S_RD1;
          default:            state_d = S_D_RD1;
        endcase
      end
      S_WR: begin
        cmd_o.use_fidx = 1'b1;
        cmd_o.tgt_row  = bpr_pkg::ROW_CTX;
        cmd_o.wsrc_in  = 1'b1;
        cmd_o.ctx_we   = !stat_i.tsel;
        cmd_o.tgt_we   = stat_i.tsel;
        state_d        = S_FIN;
      end
      S_RD1: begin
        cmd_o.use_fidx = 1'b1;
        cmd_o.tgt_row  = bpr_pkg::ROW_CTX;
        cmd_o.ctx_re   = 1'b1;
        cmd_o.tgt_re   = 1'b1;
        state_d        = S_RD2;
      end
      S_RD2: begin
        cmd_o.ld_rd = 1'b1;
        state_d     = S_FIN;
      end
      S_D_RD1: begin
        cmd_o.ctx_re  = 1'b1;
        cmd_o.tgt_re  = 1'b1;
        cmd_o.tgt_row = bpr_pkg::ROW_POS;
        state_d       = S_D_RD2;
      end
      S_D_RD2: begin
        cmd_o.ld_g    = 1'b1;
        cmd_o.ld_p    = 1'b1;
        cmd_o.tgt_re  = is_update;
        cmd_o.tgt_row = bpr_pkg::ROW_NEG;
        state_d       = is_update ? S_D_LDN : S_D_B;
      end
      S_D_LDN: begin
        cmd_o.ld_n = 1'b1;
        state_d    = S_D_B;
      end
      S_D_B: begin
        cmd_o.ld_b = 1'b1;
        state_d    = S_D_MUL;
      end
      S_D_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_D_ACC;
      end
      S_D_ACC: begin
        cmd_o.acc_add = 1'b1;
        if (f_q == F_LAST) begin
          f_d     = '0;
          state_d = S_D_SAT;
        end else begin
          f_d     = f_q + 1'b1;
          state_d = S_D_RD1;
        end
      end
      S_D_SAT: begin
        cmd_o.ld_score = 1'b1;
        state_d        = is_update ? S_LOOK : S_FIN;
      end
      S_LOOK: begin
        cmd_o.ld_d = 1'b1;
        state_d    = S_U_RD1;
      end
      S_U_RD1: begin
        cmd_o.ctx_re  = 1'b1;
        cmd_o.tgt_re  = 1'b1;
        cmd_o.tgt_row = bpr_pkg::ROW_POS;
        state_d       = S_U_RD2;
      end
      S_U_RD2: begin
        cmd_o.ld_g    = 1'b1;
        cmd_o.ld_p    = 1'b1;
        cmd_o.tgt_re  = 1'b1;
        cmd_o.tgt_row = bpr_pkg::ROW_NEG;
        state_d       = S_U_LDN;
      end
      S_U_LDN: begin
        cmd_o.ld_n = 1'b1;
        state_d    = S_U_DIFF;
      end
      S_U_DIFF: begin
        cmd_o.ld_b = 1'b1;
        op_d       = bpr_pkg::SG_CTX;
        state_d    = S_SG_A;
      end
      S_SG_A: state_d = S_SG_B;
      S_SG_B: state_d = S_SG_C;
      S_SG_C: state_d = S_SG_W;
      S_SG_W: begin
        cmd_o.sg_commit = 1'b1;
        case (op_q)
          bpr_pkg::SG_CTX: begin
            cmd_o.ctx_we = 1'b1;
            op_d         = bpr_pkg::SG_POS;
            state_d      = S_SG_A;
          end
          bpr_pkg::SG_POS: begin
            cmd_o.tgt_we  = 1'b1;
            cmd_o.tgt_row = bpr_pkg::ROW_POS;
            op_d          = bpr_pkg::SG_NEG;
            state_d       = S_SG_A;
          end
          default: begin
            cmd_o.tgt_we  = 1'b1;
            cmd_o.tgt_row = bpr_pkg::ROW_NEG;
            if (f_q == F_LAST) begin
              f_d     = '0;
              state_d = S_FIN;
            end else begin
              f_d     = f_q + 1'b1;
              state_d = S_U_RD1;
            end
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      f_q         <= '0;
      op_q        <= bpr_pkg::SG_CTX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      f_q         <= f_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/bpr_dpath.sv */
`default_nettype none

module bpr_dpath (
  input  wire logic                         clk_i,
  input  wire bpr_pkg::dp_cmd_t             cmd_i,
  input  wire bpr_pkg::in_word_t            in_data_i,
  input  wire logic [bpr_pkg::CFG_W-1:0]    step_size_i,
  input  wire logic [bpr_pkg::CFG_W-1:0]    reg_lambda_i,
  output bpr_pkg::dp_stat_t                 stat_o,
  output bpr_pkg::out_word_t                out_data_o
);

  function automatic logic [bpr_pkg::AW-1:0] row_addr(logic [bpr_pkg::ITEM_W-1:0] item,
                                                      logic [bpr_pkg::FW-1:0] f);
    logic [31:0] row;
    row = 32'(item) % bpr_pkg::NUM_ITEMS;
    return bpr_pkg::AW'(row * bpr_pkg::FACTORS + 32'(f));
  endfunction

  bpr_pkg::in_word_t      item_q;
  bpr_pkg::out_word_t     out_q;
  logic signed [31:0]     g_q, p_q, n_q, b_q, newp_q, score_q, rd_q;
  logic signed [63:0]     prod_q, prod_d;
  logic signed [bpr_pkg::ACC_W-1:0] acc_q;
  logic                   flag_q, flag_d;
  logic [15:0]            d_q;
  logic signed [48:0]     m1_q, m2_q, m1_d, m2_d;
  logic signed [31:0]     w1_q, w2_q, w3_q, sg_w, sg_x;
  logic                   neg1_q;
  logic signed [49:0]     pre_d;
  logic signed [33:0]     inner_q;
  logic signed [50:0]     m3_q, m3_d;
  logic signed [35:0]     sum_d;
  logic [32:0]            res_s, diff_s, score_s;
  logic signed [32:0]     diff_d;
  logic [bpr_pkg::FW-1:0] fsel;
  logic [bpr_pkg::ITEM_W-1:0] trow;
  logic [bpr_pkg::AW-1:0] ctx_addr, tgt_addr;
  logic [31:0]            ctx_rdata, tgt_rdata, wdata;
  logic                   alias_rows;
  logic signed [31:0]     xc;
  logic [19:0]            xoff;
  logic [19+bpr_pkg::SIG_IW:0] kprod;
  logic [bpr_pkg::SIG_IW-1:0]  kidx;

  assign fsel = cmd_i.use_fidx
              ? bpr_pkg::FW'(32'(item_q.factor_index) % bpr_pkg::FACTORS) : cmd_i.fcnt;

  always_comb begin
    case (cmd_i.tgt_row)
      bpr_pkg::ROW_POS: trow = item_q.target_item;
      bpr_pkg::ROW_NEG: trow = item_q.negative_item;
      default:          trow = item_q.context_item;
    endcase
  end

  assign ctx_addr   = row_addr(item_q.context_item, fsel);
  assign tgt_addr   = row_addr(trow, fsel);
  assign alias_rows = (row_addr(item_q.target_item, '0) == row_addr(item_q.negative_item, '0));

  bpr_ram #(.WIDTH(32), .DEPTH(bpr_pkg::NUM_ITEMS * bpr_pkg::FACTORS)) u_ctx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ctx_we),
    .waddr_i (ctx_addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.ctx_re),
    .raddr_i (ctx_addr),
    .rdata_o (ctx_rdata)
  );

  bpr_ram #(.WIDTH(32), .DEPTH(bpr_pkg::NUM_ITEMS * bpr_pkg::FACTORS)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tgt_we),
    .waddr_i (tgt_addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.tgt_re),
    .raddr_i (tgt_addr),
    .rdata_o (tgt_rdata)
  );

  assign diff_d  = 33'(p_q) - 33'(n_q);
  assign diff_s  = bpr_pkg::sat32(64'(diff_d));
  assign prod_d  = g_q * b_q;
  assign score_s = bpr_pkg::sat32(64'(acc_q));

  always_comb begin
    if (score_q < -32'sd524288) begin
      xc = -32'sd524288;
    end else if (score_q > 32'sd524287) begin
      xc = 32'sd524287;
    end else begin
      xc = score_q;
    end
    xoff  = 20'(xc + 32'sd524288);
    kprod = (20 + bpr_pkg::SIG_IW)'(xoff) * (20 + bpr_pkg::SIG_IW)'(bpr_pkg::SIG_ENTRIES);
    kidx  = kprod[20 +: bpr_pkg::SIG_IW];
  end

  always_comb begin
    sg_x = (cmd_i.sg_op == bpr_pkg::SG_CTX) ? b_q : g_q;
    case (cmd_i.sg_op)
      bpr_pkg::SG_CTX: sg_w = g_q;
      bpr_pkg::SG_POS: sg_w = p_q;
      default:         sg_w = alias_rows ? newp_q : n_q;
    endcase
    m1_d  = $signed({1'b0, d_q}) * sg_x;
    m2_d  = $signed({1'b0, reg_lambda_i}) * sg_w;
    pre_d = neg1_q ? (-50'(m1_q) - 50'(m2_q)) : (50'(m1_q) - 50'(m2_q));
    m3_d  = inner_q * $signed({1'b0, step_size_i});
    sum_d = 36'(w3_q) + 36'(m3_q >>> 16);
    res_s = bpr_pkg::sat32(64'(sum_d));
  end

  assign wdata = cmd_i.wsrc_in ? item_q.weight_value : res_s[31:0];

  always_comb begin
    flag_d = flag_q;
    if (cmd_i.cap_in) begin
      flag_d = 1'b0;
    end
    if (cmd_i.ld_b && item_q.cmd == bpr_pkg::CMD_UPDATE && diff_s[32]) begin
      flag_d = 1'b1;
    end
    if (cmd_i.ld_score && score_s[32]) begin
      flag_d = 1'b1;
    end
    if (cmd_i.sg_commit && res_s[32]) begin
      flag_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q  <= flag_d;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    w1_q    <= sg_w;
    neg1_q  <= (cmd_i.sg_op == bpr_pkg::SG_NEG);
    inner_q <= 34'(pre_d >>> 16);
    w2_q    <= w1_q;
    m3_q    <= m3_d;
    w3_q    <= w2_q;
    if (cmd_i.cap_in) begin
      item_q  <= in_data_i;
      acc_q   <= '0;
      score_q <= '0;
      rd_q    <= '0;
    end
    if (cmd_i.ld_g) begin
      g_q <= $signed(ctx_rdata);
    end
    if (cmd_i.ld_p) begin
      p_q <= $signed(tgt_rdata);
    end
    if (cmd_i.ld_n) begin
      n_q <= $signed(tgt_rdata);
    end
    if (cmd_i.ld_b) begin
      b_q <= (item_q.cmd == bpr_pkg::CMD_PREDICT) ? p_q : $signed(diff_s[31:0]);
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_add) begin
      acc_q <= acc_q + bpr_pkg::ACC_W'(prod_q >>> 16);
    end
    if (cmd_i.ld_score) begin
      score_q <= $signed(score_s[31:0]);
    end
    if (cmd_i.ld_d) begin
      d_q <= bpr_pkg::SIG_TABLE[kidx];
    end
    if (cmd_i.ld_rd) begin
      rd_q <= item_q.table_select ? $signed(tgt_rdata) : $signed(ctx_rdata);
    end
    if (cmd_i.sg_commit && cmd_i.sg_op == bpr_pkg::SG_POS) begin
      newp_q <= $signed(res_s[31:0]);
    end
    if (cmd_i.ld_out) begin
      out_q.score       <= score_q;
      out_q.read_weight <= rd_q;
      out_q.saturated   <= flag_q;
    end
  end

  assign stat_o.cmd  = item_q.cmd;
  assign stat_o.tsel = item_q.table_select;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/bpr_factor_sgd_update_unit.sv */
`default_nettype none

// Pairwise SGD update unit over a context and a target embedding table, each a
// single-port-read, single-port-write RAM of NUM_ITEMS*FACTORS Q16.16 words.
// One word is handled at a time. In an update, the dot product reads the
// negative row through the same target read port as the positive row, and each
// factor then sends its three weights one after another through a multiply
// pipeline (states SG_A, SG_B, SG_C and SG_W) that is shared by all three.
// Table contents are undefined until written; the user must write the step size
// (index 0) and reg_lambda (index 1) only while the unit is idle, and the unit
// itself has no check that enforces this.
module bpr_factor_sgd_update_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire bpr_pkg::in_word_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output bpr_pkg::out_word_t             out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_index_i,
  input  wire logic [bpr_pkg::CFG_W-1:0] cfg_data_i
);

  logic [bpr_pkg::CFG_W-1:0] step_size_q, reg_lambda_q;
  bpr_pkg::dp_cmd_t          dp_cmd;
  bpr_pkg::dp_stat_t         dp_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q  <= bpr_pkg::STEP_SIZE_RESET;
      reg_lambda_q <= bpr_pkg::REG_LAMBDA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bpr_pkg::REG_STEP_SIZE: step_size_q  <= cfg_data_i;
        bpr_pkg::REG_LAMBDA:    reg_lambda_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  bpr_dpath u_dpath (
    .clk_i        (clk_i),
    .cmd_i        (dp_cmd),
    .in_data_i    (in_data_i),
    .step_size_i  (step_size_q),
    .reg_lambda_i (reg_lambda_q),
    .stat_o       (dp_stat),
    .out_data_o   (out_data_o)
  );

  a_one_table_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd.ctx_we && dp_cmd.tgt_we))
    else $error("both tables written in one cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a word was accepted");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a word in progress");

  a_commit_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.sg_commit |-> (dp_cmd.ctx_we || dp_cmd.tgt_we))
    else $error("weight update committed without a table write");

endmodule

`default_nettype wire
